// ===== src/request_id_remap_table_defines.svh =====
// ----------------------------------------------------------------------------
// Request id remap table: assertion macros
// Shared concurrent assertion wrappers, sampled on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef REQUEST_ID_REMAP_TABLE_DEFINES_SVH
`define REQUEST_ID_REMAP_TABLE_DEFINES_SVH

// same-cycle implication
`define RIT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RIT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/rit_pkg.sv =====
// ----------------------------------------------------------------------------
// Request id remap table package
// Field widths, register indexes, opcodes, status codes and payload types.
// ----------------------------------------------------------------------------
package rit_pkg;

	localparam int unsigned FRESH_W    = 20;
	localparam int unsigned LIMIT_W    = 21;
	localparam int unsigned ORIG_W     = 16;
	localparam int unsigned HANDLE_W   = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 21;

	localparam logic [FRESH_W-1:0] ID_BASE_RESET  = 20'd5000;
	localparam logic [LIMIT_W-1:0] ID_LIMIT_RESET = 21'd1000000;

	localparam logic [CFG_IDX_W-1:0] CFG_ID_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ID_LIMIT = 2'd1;

	typedef enum logic {
		FUNC_ALLOC   = 1'b0,
		FUNC_RELEASE = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef struct packed {
		func_t                func;
		logic [ORIG_W-1:0]    orig_id;
		logic [HANDLE_W-1:0]  client_handle;
		logic [FRESH_W-1:0]   release_id;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic [FRESH_W-1:0]   fresh_id;
		logic [ORIG_W-1:0]    stored_orig_id;
		logic [HANDLE_W-1:0]  stored_handle;
	} rsp_t;

endpackage

// ===== src/rit_if.sv =====
// ----------------------------------------------------------------------------
// Request id remap table channels
// Valid/ready channels for requests in and results out.
// ----------------------------------------------------------------------------
interface rit_req_if;
	import rit_pkg::*;

	logic valid;
	logic ready;
	req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface rit_rsp_if;
	import rit_pkg::*;

	logic valid;
	logic ready;
	rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== src/request_id_remap_table.sv =====
// ----------------------------------------------------------------------------
// Request id remap table
// Maps client request ids to fresh sequential ids in a small slot table.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | func, orig_id, client_handle, release_id
//  rsp     | out | status, fresh_id, stored_orig_id, stored_handle
//  cfg     | in  | cfg_wr_en, cfg_index, cfg_wdata (write only)
//
// One request per cycle unless rsp stalls; an input register and a result register,
// with the slot lookup, free-slot pick and counter advance between the two.
// Reset clears all slot valid bits and loads the counter with the id_base reset.
// A stalled result holds in its register while one more request waits behind it.
// ----------------------------------------------------------------------------
`include "request_id_remap_table_defines.svh"

module request_id_remap_table #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [rit_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rit_pkg::CFG_DATA_W-1:0] cfg_wdata,
	rit_req_if.sink                       req,
	rit_rsp_if.source                     rsp
);
	import rit_pkg::*;

	logic [FRESH_W-1:0] id_base_q;
	logic [LIMIT_W-1:0] id_limit_q;
	logic [FRESH_W-1:0] next_fresh_q;

	logic [DEPTH-1:0]    slot_valid_q;
	logic [FRESH_W-1:0]  slot_fid_q    [DEPTH];
	logic [ORIG_W-1:0]   slot_orig_q   [DEPTH];
	logic [HANDLE_W-1:0] slot_handle_q [DEPTH];

	logic v_s1;
	req_t req_s1;
	logic v_s2;
	rsp_t rsp_s2;

	logic adv;
	logic fire;
	logic is_alloc;
	logic alloc_ok;
	logic rel_hit;
	logic [DEPTH-1:0] free_vec;
	logic [DEPTH-1:0] free_oh;
	logic [DEPTH-1:0] match_vec;
	logic [DEPTH-1:0] match_oh;
	logic [ORIG_W-1:0]   hit_orig;
	logic [HANDLE_W-1:0] hit_handle;
	logic [LIMIT_W-1:0]  cnt_inc;
	logic [FRESH_W-1:0]  cnt_next;
	rsp_t rsp_d;

	// handshake
	assign adv       = !v_s2 || rsp.ready;
	assign fire      = v_s1 && adv;
	assign req.ready = !v_s1 || adv;
	assign rsp.valid = v_s2;
	assign rsp.payload = rsp_s2;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_base_q  <= ID_BASE_RESET;
			id_limit_q <= ID_LIMIT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_ID_BASE:  id_base_q  <= cfg_wdata[FRESH_W-1:0];
				CFG_ID_LIMIT: id_limit_q <= cfg_wdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// lookup and pick
	assign is_alloc = (req_s1.func == FUNC_ALLOC);
	assign free_vec = ~slot_valid_q;
	assign free_oh  = free_vec & (~free_vec + DEPTH'(1));

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			match_vec[i] = slot_valid_q[i] && (slot_fid_q[i] == req_s1.release_id);
		end
	end

	assign match_oh = match_vec & (~match_vec + DEPTH'(1));
	assign alloc_ok = is_alloc && (|free_vec);
	assign rel_hit  = !is_alloc && (|match_vec);

	always_comb begin
		hit_orig   = '0;
		hit_handle = '0;
		for (int i = 0; i < DEPTH; i++) begin
			hit_orig   = hit_orig   | (slot_orig_q[i]   & {ORIG_W{match_oh[i]}});
			hit_handle = hit_handle | (slot_handle_q[i] & {HANDLE_W{match_oh[i]}});
		end
	end

	// wrap to base when the increment reaches the limit or overflows the field width
	assign cnt_inc  = {1'b0, next_fresh_q} + LIMIT_W'(1);
	assign cnt_next = (cnt_inc[LIMIT_W-1] || (cnt_inc >= id_limit_q)) ?
		id_base_q : cnt_inc[FRESH_W-1:0];

	always_comb begin
		rsp_d = '0;
		if (is_alloc) begin
			if (alloc_ok) begin
				rsp_d.status   = ST_OK;
				rsp_d.fresh_id = next_fresh_q;
			end else begin
				rsp_d.status = ST_FULL;
			end
		end else begin
			rsp_d.fresh_id = req_s1.release_id;
			if (rel_hit) begin
				rsp_d.status         = ST_OK;
				rsp_d.stored_orig_id = hit_orig;
				rsp_d.stored_handle  = hit_handle;
			end else begin
				rsp_d.status = ST_NOT_FOUND;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			slot_valid_q <= '0;
			next_fresh_q <= ID_BASE_RESET;
		end else begin
			if (req.ready) begin
				v_s1 <= req.valid;
			end
			if (adv) begin
				v_s2 <= v_s1;
			end
			if (fire) begin
				slot_valid_q <= (slot_valid_q | (alloc_ok ? free_oh : '0)) &
					~(rel_hit ? match_oh : '0);
				if (alloc_ok) begin
					next_fresh_q <= cnt_next;
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1 <= req.payload;
		end
		if (fire) begin
			rsp_s2 <= rsp_d;
		end
		for (int i = 0; i < DEPTH; i++) begin
			if (fire && alloc_ok && free_oh[i]) begin
				slot_fid_q[i]    <= next_fresh_q;
				slot_orig_q[i]   <= req_s1.orig_id;
				slot_handle_q[i] <= req_s1.client_handle;
			end
		end
	end

	// assertions
	`RIT_ASSERT_NEXT(a_full_when_no_slot,
		fire && is_alloc && (&slot_valid_q),
		rsp_s2.status == ST_FULL,
		"allocate with every slot taken did not report full")

	`RIT_ASSERT_NEXT(a_slots_idle_stable,
		!fire,
		$stable(slot_valid_q),
		"slot valid bits changed without a request in flight")

	`RIT_ASSERT_NEXT(a_one_slot_per_request,
		1'b1,
		($countones(slot_valid_q) <= $countones($past(slot_valid_q)) + 1) &&
		($countones(slot_valid_q) + 1 >= $countones($past(slot_valid_q))),
		"more than one slot changed in a cycle")

	`RIT_ASSERT_NOW(a_full_result_zero,
		v_s2 && (rsp_s2.status == ST_FULL),
		(rsp_s2.fresh_id == '0) && (rsp_s2.stored_orig_id == '0) &&
		(rsp_s2.stored_handle == '0),
		"full result carries nonzero fields")

	`RIT_ASSERT_NEXT(a_counter_holds,
		!(fire && alloc_ok),
		$stable(next_fresh_q),
		"id counter moved without a granted allocate")

endmodule
